FILE: sv/frp_pkg.sv
// Shared types and codes for the flag reachability propagate unit.
// No dependencies.
package frp_pkg;

  localparam logic [1:0] OP_SET  = 2'd0;
  localparam logic [1:0] OP_EDGE = 2'd1;
  localparam logic [1:0] OP_PROP = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_PROP = 1'b1;

  typedef struct packed {
    logic [1:0] op;
    logic [9:0] node;
    logic [9:0] child;
    logic       flag;
    logic       node_ok;
    logic       edge_ok;
  } cmd_t;

  typedef struct packed {
    logic        kind;
    logic        flag;
    logic [10:0] marked;
    logic        ovf;
  } result_t;

endpackage

FILE: sv/frp_front.sv
// Front end: accepts input transfers, range-checks node indices and queues
// classified commands for the engine. Depends on frp_pkg.
module frp_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_op,
  input  logic [9:0]    in_node,
  input  logic [9:0]    in_child,
  input  logic          in_flag,
  input  logic [10:0]   live,
  output logic          q_valid,
  output frp_pkg::cmd_t q_cmd,
  input  logic          q_pop
);
  import frp_pkg::*;

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  cmd_t       cmd;

  always_comb begin
    cmd.op      = in_op;
    cmd.node    = in_node;
    cmd.child   = in_child;
    cmd.flag    = in_flag;
    cmd.node_ok = {1'b0, in_node} < live;
    cmd.edge_ok = ({1'b0, in_node} < live) && ({1'b0, in_child} < live);
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: sv/frp_back.sv
// Engine: flag and edge stores, graph walk by repeated edge sweeps to a
// fixed point, and the result register. Depends on frp_pkg.
module frp_back #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [10:0]      live,
  input  logic             q_valid,
  input  frp_pkg::cmd_t    q_cmd,
  output logic             q_pop,
  output logic             clearing,
  output logic             out_valid,
  input  logic             out_ready,
  output frp_pkg::result_t out_res
);
  import frp_pkg::*;

  localparam int FD = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam int FW = $clog2(FD);
  localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EC = $clog2(MAX_EDGES + 1);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_EREAD = 3'd3;
  localparam logic [2:0] S_FREAD = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic          fmem [FD];
  logic [19:0]   emem [MAX_EDGES];

  logic [2:0]    st_r, st_nxt;
  logic [FW-1:0] clr_r, clr_nxt;
  logic [EC-1:0] loaded_r, loaded_nxt;
  logic [EC-1:0] idx_r, idx_nxt;
  logic [10:0]   marked_r, marked_nxt;
  logic          chg_r, chg_nxt;
  logic          ovf_r, ovf_nxt;
  logic          rd_ok_r, rd_ok_nxt;
  logic          ov_r, ov_nxt;
  result_t       res_r, res_nxt;

  logic          f_we, f_wd;
  logic [FW-1:0] f_wa, f_ra, f_rb;
  logic          fa_r, fb_r;
  logic          e_we;
  logic [EA-1:0] e_ra;
  logic [19:0]   ed_r;
  logic          e_ok;

  always_ff @(posedge clk) begin
    if (f_we) fmem[f_wa] <= f_wd;
    fa_r <= fmem[f_ra];
    fb_r <= fmem[f_rb];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[loaded_r[EA-1:0]] <= {q_cmd.child, q_cmd.node};
    ed_r <= emem[e_ra];
  end

  assign e_ok = ({1'b0, ed_r[9:0]} < live) && ({1'b0, ed_r[19:10]} < live);

  assign clearing  = (st_r == S_CLR);
  assign out_valid = ov_r;
  assign out_res   = res_r;

  always_comb begin
    st_nxt     = st_r;
    clr_nxt    = clr_r;
    loaded_nxt = loaded_r;
    idx_nxt    = idx_r;
    marked_nxt = marked_r;
    chg_nxt    = chg_r;
    ovf_nxt    = ovf_r;
    rd_ok_nxt  = rd_ok_r;
    ov_nxt     = ov_r && !out_ready;
    res_nxt    = res_r;
    q_pop      = 1'b0;
    f_we       = 1'b0;
    f_wd       = 1'b0;
    f_wa       = q_cmd.node[FW-1:0];
    f_ra       = q_cmd.node[FW-1:0];
    f_rb       = ed_r[10 +: FW];
    e_we       = 1'b0;
    e_ra       = idx_r[EA-1:0];
    case (st_r)
      S_CLR: begin
        f_we    = 1'b1;
        f_wa    = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == FW'(FD - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid && !ov_r) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_SET: begin
              f_we = q_cmd.node_ok;
              f_wd = q_cmd.flag;
            end
            OP_EDGE: begin
              if (q_cmd.edge_ok) begin
                if (loaded_r < EC'(MAX_EDGES)) begin
                  e_we       = 1'b1;
                  loaded_nxt = loaded_r + 1'b1;
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            OP_PROP: begin
              idx_nxt    = '0;
              marked_nxt = '0;
              chg_nxt    = 1'b0;
              st_nxt     = (loaded_r == '0) ? S_DONE : S_EREAD;
            end
            default: begin
              rd_ok_nxt = q_cmd.node_ok;
              st_nxt    = S_RD;
            end
          endcase
        end
      end
      S_RD: begin
        ov_nxt      = 1'b1;
        res_nxt.kind   = KIND_READ;
        res_nxt.flag   = rd_ok_r & fa_r;
        res_nxt.marked = '0;
        res_nxt.ovf    = ovf_r;
        st_nxt      = S_IDLE;
      end
      S_EREAD: begin
        st_nxt = S_FREAD;
      end
      S_FREAD: begin
        f_ra   = ed_r[FW-1:0];
        st_nxt = S_EVAL;
      end
      S_EVAL: begin
        f_wa = ed_r[10 +: FW];
        f_wd = 1'b1;
        if (e_ok && fa_r && !fb_r) begin
          f_we       = 1'b1;
          marked_nxt = marked_r + 1'b1;
          chg_nxt    = 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
        st_nxt  = S_EREAD;
        if (idx_r + 1'b1 == loaded_r) begin
          idx_nxt = '0;
          if (chg_nxt) begin
            chg_nxt = 1'b0;
          end else begin
            st_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        ov_nxt         = 1'b1;
        res_nxt.kind   = KIND_PROP;
        res_nxt.flag   = 1'b0;
        res_nxt.marked = marked_r;
        res_nxt.ovf    = ovf_r;
        st_nxt         = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_CLR;
      clr_r    <= '0;
      loaded_r <= '0;
      ovf_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      loaded_r <= loaded_nxt;
      ovf_r    <= ovf_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    marked_r <= marked_nxt;
    chg_r    <= chg_nxt;
    rd_ok_r  <= rd_ok_nxt;
    res_r    <= res_nxt;
  end

endmodule

FILE: sv/flag_reachability_propagate_unit.sv
// Flag reachability propagate unit: set and edge transfers are taken one per
// cycle while the engine is idle and no result waits; a read or a propagate holds the
// engine until its result is taken. A propagate sweeps the edge store, each edge passing
// the edge read, flag read and evaluate states, repeating sweeps until no flag changes.
// After reset a clearing pass zeroes all min(MAX_NODES,1024) flag memory entries;
// no input transfer is taken during it. Depends on frp_pkg, frp_front and frp_back.
module flag_reachability_propagate_unit #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // node_index[9:0], child_index[19:10], flag_value[20]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // flag_out[0], marked_count[11:1], edge_overflow[12]
  output logic        out_tuser,  // result_kind[0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import frp_pkg::*;

  logic [10:0] node_count_r;
  logic [10:0] live;
  logic        f_ready, q_valid, q_pop, clearing;
  cmd_t        q_cmd;
  result_t     res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {21'd0, node_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 11'd1024;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      node_count_r <= cfg_pwdata[10:0];
    end
  end

  assign live = ({21'd0, node_count_r} < 32'(MAX_NODES)) ? node_count_r : 11'(MAX_NODES);

  assign in_tready = f_ready && !clearing;

  frp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid && !clearing),
    .in_ready (f_ready),
    .in_op    (in_tuser),
    .in_node  (in_tdata[9:0]),
    .in_child (in_tdata[19:10]),
    .in_flag  (in_tdata[20]),
    .live     (live),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  frp_back #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .live      (live),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clearing  (clearing),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {3'd0, res.ovf, res.marked, res.flag};
  assign out_tuser = res.kind;

endmodule
